// ----- rtl/png_chunk_header_extractor_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef PNG_CHUNK_HEADER_EXTRACTOR_MACROS_SVH
`define PNG_CHUNK_HEADER_EXTRACTOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PNGCHX_HOLDS(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pngchx: same-cycle rule broken");

// Consequent must hold in the cycle after the antecedent.
`define PNGCHX_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pngchx: next-cycle rule broken");

`endif

// ----- rtl/pngchx_pkg.sv -----
`default_nettype none

package pngchx_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} src_t;

	typedef struct packed {
		logic [1:0]  record;
		logic        present;
		logic [31:0] word_a;
		logic [31:0] word_b;
		logic [15:0] word_c;
		logic [15:0] word_d;
		logic [7:0]  byte_a;
		logic [7:0]  byte_b;
		logic [7:0]  byte_c;
		logic [7:0]  byte_d;
		logic [7:0]  byte_e;
		logic        last_record;
	} rec_t;

	// Everything the three records report, as committed so far
	typedef struct packed {
		logic            hdr_found;
		logic [31:0]     img_w;
		logic [31:0]     img_h;
		logic [4:0][7:0] hdr_small;
		logic            res_found;
		logic [31:0]     res_x;
		logic [31:0]     res_y;
		logic [7:0]      res_unit;
		logic [1:0]      bg_kind;
		logic [15:0]     bg_gray;
		logic [15:0]     bg_red;
		logic [15:0]     bg_green;
		logic [15:0]     bg_blue;
		logic [7:0]      bg_index;
	} rec_set_t;

	localparam logic [1:0] REC_HEADER     = 2'd0;
	localparam logic [1:0] REC_RESOLUTION = 2'd1;
	localparam logic [1:0] REC_BACKGROUND = 2'd2;

	localparam logic [1:0] BG_NONE    = 2'd0;
	localparam logic [1:0] BG_GRAY    = 2'd1;
	localparam logic [1:0] BG_RGB     = 2'd2;
	localparam logic [1:0] BG_PALETTE = 2'd3;

	localparam logic [7:0] SIG [4] = '{8'h89, 8'h50, 8'h4E, 8'h47};

	localparam logic [31:0] KIND_IHDR = 32'h4948_4452;
	localparam logic [31:0] KIND_PHYS = 32'h7048_5973;
	localparam logic [31:0] KIND_BKGD = 32'h624B_4744;
	localparam logic [31:0] KIND_IEND = 32'h4945_4E44;

	localparam logic [31:0] IHDR_MIN_LEN  = 32'd13;
	localparam logic [31:0] PHYS_MIN_LEN  = 32'd9;
	localparam logic [31:0] BKGD_PAL_LEN  = 32'd1;
	localparam logic [31:0] BKGD_GRAY_LEN = 32'd2;
	localparam logic [31:0] BKGD_RGB_LEN  = 32'd6;

	// Data bytes that any commit reads
	localparam int HDR_BYTES = 13;

endpackage

`default_nettype wire

// ----- rtl/pngchx_walk.sv -----
`default_nettype none

module pngchx_walk #(
	parameter int CAPTURE_DEPTH = 13
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire pngchx_pkg::src_t     word,
	output pngchx_pkg::rec_set_t      snap
);

	localparam int IW = $clog2(CAPTURE_DEPTH);

	logic [3:0]  lead_q;
	logic        sig_q;
	logic [32:0] pos_q;
	logic [31:0] len_q;
	logic [31:0] kind_q;
	logic        halted_q;
	logic [7:0]  cap_q [CAPTURE_DEPTH];
	pngchx_pkg::rec_set_t st_q;
	pngchx_pkg::rec_set_t st_d;

	logic [7:0]    b;
	logic          in_lead;
	logic          walk;
	logic          past_hdr;
	logic [31:0]   kind_sh;
	logic [32:0]   off;
	logic          cap_we;
	logic [IW-1:0] cap_idx;
	logic [32:0]   commit_at;
	logic [32:0]   chunk_last;
	logic          commit;
	logic          chunk_end;
	logic [7:0]    cv [pngchx_pkg::HDR_BYTES];

	always_comb begin
		b          = word.data_byte;
		in_lead    = !lead_q[3];
		walk       = !in_lead && sig_q && !halted_q;
		past_hdr   = pos_q >= 33'd8;
		kind_sh    = {kind_q[23:0], b};
		off        = pos_q - 33'd8;
		cap_we     = walk && past_hdr && (off < {1'b0, len_q})
		             && (off < 33'(CAPTURE_DEPTH));
		cap_idx    = off[IW-1:0];
		commit_at  = (len_q < 32'd4) ? 33'd11 : ({1'b0, len_q} + 33'd7);
		chunk_last = {1'b0, len_q} + 33'd11;
		commit     = walk && past_hdr && (pos_q == commit_at);
		chunk_end  = walk && past_hdr && (pos_q == chunk_last);
	end

	// Forward the byte being captured: the commit byte is the last data byte, or data offset 3 if shorter
	always_comb begin
		for (int k = 0; k < pngchx_pkg::HDR_BYTES; k++) begin
			cv[k] = (cap_we && cap_idx == IW'(k)) ? b : cap_q[k];
		end
	end

	always_comb begin
		st_d = st_q;
		if (commit) begin
			priority if (kind_q == pngchx_pkg::KIND_IHDR && len_q >= pngchx_pkg::IHDR_MIN_LEN) begin
				st_d.img_w     = {cv[0], cv[1], cv[2], cv[3]};
				st_d.img_h     = {cv[4], cv[5], cv[6], cv[7]};
				for (int i = 0; i < 5; i++) begin
					st_d.hdr_small[i] = cv[8 + i];
				end
				st_d.hdr_found = 1'b1;
			end else if (kind_q == pngchx_pkg::KIND_PHYS
			             && len_q >= pngchx_pkg::PHYS_MIN_LEN) begin
				st_d.res_x     = {cv[0], cv[1], cv[2], cv[3]};
				st_d.res_y     = {cv[4], cv[5], cv[6], cv[7]};
				st_d.res_unit  = cv[8];
				st_d.res_found = 1'b1;
			end else if (kind_q == pngchx_pkg::KIND_BKGD) begin
				priority if (len_q == pngchx_pkg::BKGD_PAL_LEN) begin
					st_d.bg_index = cv[0];
					st_d.bg_kind  = pngchx_pkg::BG_PALETTE;
				end else if (len_q == pngchx_pkg::BKGD_GRAY_LEN) begin
					st_d.bg_gray = {cv[0], cv[1]};
					st_d.bg_kind = pngchx_pkg::BG_GRAY;
				end else if (len_q == pngchx_pkg::BKGD_RGB_LEN) begin
					st_d.bg_red   = {cv[0], cv[1]};
					st_d.bg_green = {cv[2], cv[3]};
					st_d.bg_blue  = {cv[4], cv[5]};
					st_d.bg_kind  = pngchx_pkg::BG_RGB;
				end else begin
					st_d.bg_kind = st_q.bg_kind;
				end
			end else begin
				st_d.hdr_found = st_q.hdr_found;
			end
		end
	end

	assign snap = st_d;

	always_ff @(posedge clk) begin
		if (step && cap_we) begin
			cap_q[cap_idx] <= b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q   <= '0;
			sig_q    <= 1'b0;
			pos_q    <= '0;
			len_q    <= '0;
			kind_q   <= '0;
			halted_q <= 1'b0;
			st_q     <= '0;
		end else if (step) begin
			if (word.end_of_file) begin
				// drop the walk and record state, ready for the next file
				lead_q   <= '0;
				sig_q    <= 1'b0;
				pos_q    <= '0;
				len_q    <= '0;
				kind_q   <= '0;
				halted_q <= 1'b0;
				st_q     <= '0;
			end else begin
				if (in_lead) begin
					lead_q <= lead_q + 4'd1;
					if (lead_q == 4'd0) begin
						sig_q <= (b == pngchx_pkg::SIG[0]);
					end else if (lead_q < 4'd4 && b != pngchx_pkg::SIG[lead_q[1:0]]) begin
						sig_q <= 1'b0;
					end
				end
				if (walk) begin
					if (pos_q < 33'd4) begin
						len_q <= {len_q[23:0], b};
					end else if (pos_q < 33'd8) begin
						kind_q <= kind_sh;
						if (pos_q == 33'd7 && kind_sh == pngchx_pkg::KIND_IEND) begin
							halted_q <= 1'b1;
						end
					end
					if (chunk_end) begin
						pos_q  <= '0;
						len_q  <= '0;
						kind_q <= '0;
					end else begin
						pos_q <= pos_q + 33'd1;
					end
				end
				st_q <= st_d;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/png_chunk_header_extractor.sv -----
// Channel  Handshake                Word                   Direction
// src      src_valid / src_ready    pngchx_pkg::src_t      file bytes in
// rec      rec_valid / rec_ready    pngchx_pkg::rec_t      records out
//
// One byte is taken per cycle unless an end-of-file byte is held, and each byte passes the input register.
// An end-of-file byte yields three records, one per cycle while rec_ready is high,
// the first valid in the cycle after that byte leaves the input register.
// The record register holds one file's three records: an end-of-file byte waits in
// the input register until the previous file's records have drained; others pass.
// Reset (arst_n low) clears the walk state but for the capture bytes, and drops pending records.
`default_nettype none

module png_chunk_header_extractor #(
	parameter int CAPTURE_DEPTH = 13
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              src_valid,
	output logic                   src_ready,
	input  wire pngchx_pkg::src_t  src_word,
	output logic                   rec_valid,
	input  wire logic              rec_ready,
	output pngchx_pkg::rec_t       rec_word
);

	logic                 valid_s1;
	pngchx_pkg::src_t     src_s1;
	logic                 go_s1;
	logic                 snap_free;
	logic                 snap_load;
	pngchx_pkg::rec_set_t snap;
	pngchx_pkg::rec_set_t snap_q;
	logic                 snap_valid_q;
	logic [1:0]           idx_q;

	assign snap_free = !snap_valid_q || (rec_ready && idx_q == pngchx_pkg::REC_BACKGROUND);
	// hold an end-of-file word until the record register is free
	assign go_s1     = valid_s1 && (!src_s1.end_of_file || snap_free);
	assign snap_load = go_s1 && src_s1.end_of_file;
	assign src_ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ready) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ready && src_valid) begin
			src_s1 <= src_word;
		end
	end

	pngchx_walk #(
		.CAPTURE_DEPTH(CAPTURE_DEPTH)
	) u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (go_s1),
		.word   (src_s1),
		.snap   (snap)
	);

	always_ff @(posedge clk) begin
		if (snap_load) begin
			snap_q <= snap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_q <= 1'b0;
			idx_q        <= pngchx_pkg::REC_HEADER;
		end else if (snap_load) begin
			snap_valid_q <= 1'b1;
			idx_q        <= pngchx_pkg::REC_HEADER;
		end else if (rec_valid && rec_ready) begin
			if (idx_q == pngchx_pkg::REC_BACKGROUND) begin
				snap_valid_q <= 1'b0;
				idx_q        <= pngchx_pkg::REC_HEADER;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	assign rec_valid = snap_valid_q;

	always_comb begin
		rec_word             = '0;
		rec_word.record      = idx_q;
		rec_word.last_record = (idx_q == pngchx_pkg::REC_BACKGROUND);
		unique case (idx_q)
			pngchx_pkg::REC_HEADER: begin
				rec_word.present = snap_q.hdr_found;
				rec_word.word_a  = snap_q.img_w;
				rec_word.word_b  = snap_q.img_h;
				rec_word.byte_a  = snap_q.hdr_small[0];
				rec_word.byte_b  = snap_q.hdr_small[1];
				rec_word.byte_c  = snap_q.hdr_small[2];
				rec_word.byte_d  = snap_q.hdr_small[3];
				rec_word.byte_e  = snap_q.hdr_small[4];
			end
			pngchx_pkg::REC_RESOLUTION: begin
				rec_word.present = snap_q.res_found;
				rec_word.word_a  = snap_q.res_x;
				rec_word.word_b  = snap_q.res_y;
				rec_word.byte_a  = snap_q.res_unit;
			end
			pngchx_pkg::REC_BACKGROUND: begin
				rec_word.present = (snap_q.bg_kind != pngchx_pkg::BG_NONE);
				rec_word.word_a  = {16'd0, snap_q.bg_gray};
				rec_word.word_b  = {16'd0, snap_q.bg_red};
				rec_word.word_c  = snap_q.bg_green;
				rec_word.word_d  = snap_q.bg_blue;
				rec_word.byte_a  = {6'd0, snap_q.bg_kind};
				rec_word.byte_b  = snap_q.bg_index;
			end
			default: begin
				rec_word = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/pngchx_checker.sv -----
`default_nettype none
`include "png_chunk_header_extractor_macros.svh"

module pngchx_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             src_valid,
	input wire logic             src_ready,
	input wire pngchx_pkg::src_t src_word,
	input wire logic             rec_valid,
	input wire logic             rec_ready,
	input wire pngchx_pkg::rec_t rec_word
);

	logic rec_take;
	logic src_take;

	assign rec_take = rec_valid && rec_ready;
	assign src_take = src_valid && src_ready && (src_word.end_of_file || !src_word.end_of_file);

	`PNGCHX_NEXT(a_rec_hold, rec_valid && !rec_ready, rec_valid && $stable(rec_word))
	`PNGCHX_HOLDS(a_last_flag, rec_valid, rec_word.last_record == (rec_word.record == pngchx_pkg::REC_BACKGROUND))
	`PNGCHX_NEXT(a_hdr_then_res, rec_take && rec_word.record == pngchx_pkg::REC_HEADER, rec_valid && rec_word.record == pngchx_pkg::REC_RESOLUTION)
	`PNGCHX_NEXT(a_res_then_bg, rec_take && rec_word.record == pngchx_pkg::REC_RESOLUTION, rec_valid && rec_word.record == pngchx_pkg::REC_BACKGROUND)
	`PNGCHX_HOLDS(a_hdr_absent_zero, rec_valid && !rec_word.present && rec_word.record == pngchx_pkg::REC_HEADER && (src_take || !src_take), rec_word.word_a == 32'd0 && rec_word.word_b == 32'd0 && rec_word.word_c == 16'd0)

endmodule

bind png_chunk_header_extractor pngchx_checker u_pngchx_checker (.*);

`default_nettype wire
